// File: design/ips_pkg.sv
// shared types and constants for the interval profiler slot table
`default_nettype none

package ips_pkg;

    localparam int STAMP_W = 48;
    localparam int COUNT_W = 32;
    localparam int SUM_W   = 64;

    // command codes
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_STOP  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ABSENT   = 2'd1;
    localparam logic [1:0] ST_NO_START = 2'd2;
    localparam logic [1:0] ST_IGNORED  = 2'd3;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [3:0]         slot;
        logic               skip;
        logic [STAMP_W-1:0] now;
    } item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [STAMP_W-1:0] elapsed;
        logic [COUNT_W-1:0] call_count;
        logic [SUM_W-1:0]   total_time;
        logic [STAMP_W-1:0] max_time;
        logic [STAMP_W-1:0] min_time;
        logic [COUNT_W-1:0] restart_count;
    } result_t;

    // per-slot record kept in the slot memory
    typedef struct packed {
        logic               running;
        logic [STAMP_W-1:0] stamp;
        logic [COUNT_W-1:0] calls;
        logic [SUM_W-1:0]   sum;
        logic [STAMP_W-1:0] tmax;
        logic [STAMP_W-1:0] tmin;
        logic [COUNT_W-1:0] restarts;
    } rec_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } ctl_t;

endpackage

`default_nettype wire

// File: design/interval_profiler_slots.sv
// top level of the interval profiler slot table
`default_nettype none
//
// usage:
// - a command transaction (start, stop, read, clear) is taken at a rising edge
//   with start high and busy low; the item carries cmd, slot, skip and now
// - every command gives exactly one result, shown on result for one cycle
//   with done high; the receiver cannot hold it off
// - timing: busy is high in the cycle after the accepting edge, done is
//   high in the cycle after that, and a new command can be taken once busy
//   is low again, already in the cycle in which done is high
// - the pace comes from the slot memory: the slot record is read at load,
//   then updated and written back at execute
// - config: enable is written by a cfg_valid/cfg_ready transaction (ready is
//   always high); write it only while the block is idle
// - reset: all slots absent, enable set to 1, no result pending; the record
//   memory itself is not cleared, records of absent slots are never used
module interval_profiler_slots #(
    parameter int SLOTS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire ips_pkg::item_t    item,
    output logic                   done,
    output ips_pkg::result_t       result,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_data
);

    ips_pkg::ctl_t ctl;

    // config writes always land at once
    assign cfg_ready = 1'b1;

    // sequencing: idle -> execute -> idle
    ips_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctl   (ctl)
    );

    // slot table, presence bits, statistics update
    ips_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .item     (item),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .result   (result)
    );

    // a result is shown only once the block is free again
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // an accepted command keeps the block busy for exactly one cycle
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    assert property (@(posedge clk) disable iff (!rst_n) busy |=> (!busy && done))
        else $error("execute did not finish with a result");

    // only a successful stop reports an elapsed time
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != ips_pkg::ST_OK)) |-> (result.elapsed == '0))
        else $error("elapsed time on a failed command");

endmodule

`default_nettype wire

// File: design/ips_ctrl.sv
// controller for the interval profiler: load then execute, one transaction at a time
`default_nettype none

module ips_ctrl (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    output logic             done,
    output ips_pkg::ctl_t    ctl
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctl.exec   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= ctl.exec;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

`default_nettype wire

// File: design/ips_dpath.sv
// datapath for the interval profiler: slot memory, presence bits and update logic
`default_nettype none

module ips_dpath #(
    parameter int SLOTS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ips_pkg::ctl_t    ctl,
    input  wire ips_pkg::item_t   item,
    input  wire logic             cfg_we,
    input  wire logic             cfg_data,
    output ips_pkg::result_t      result
);

    localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IW      = (SLOT_AW > 4) ? SLOT_AW : 4;

    ips_pkg::rec_t    mem [SLOTS];
    ips_pkg::rec_t    rd_reg;
    ips_pkg::item_t   item_reg;
    ips_pkg::result_t result_reg;
    logic [SLOTS-1:0] present_reg;
    logic             enable_reg;

    logic [IW-1:0]      in_wide;
    logic [IW-1:0]      q_wide;
    logic [SLOT_AW-1:0] in_idx;
    logic [SLOT_AW-1:0] q_idx;
    logic               slot_ok;
    logic               sel_ok;

    ips_pkg::rec_t    fresh;
    ips_pkg::rec_t    base;
    ips_pkg::rec_t    wrec;
    ips_pkg::result_t res;
    logic             we;
    logic             set_present;
    logic             clear_all;

    logic [ips_pkg::STAMP_W-1:0] et;
    logic [ips_pkg::SUM_W:0]     sum_wide;

    function automatic ips_pkg::result_t stats(input ips_pkg::rec_t r, input logic [1:0] st);
        ips_pkg::result_t o;
        o               = '0;
        o.status        = st;
        o.call_count    = r.calls;
        o.total_time    = r.sum;
        o.max_time      = r.tmax;
        o.min_time      = r.tmin;
        o.restart_count = r.restarts;
        return o;
    endfunction

    assign in_wide = IW'(item.slot);
    assign q_wide  = IW'(item_reg.slot);
    assign in_idx  = in_wide[SLOT_AW-1:0];
    assign q_idx   = q_wide[SLOT_AW-1:0];
    assign slot_ok = (32'(item_reg.slot) < 32'(SLOTS));
    assign sel_ok  = slot_ok && present_reg[q_idx];

    always_comb
    begin
        fresh         = '0;
        fresh.tmin    = '1;
        base          = sel_ok ? rd_reg : fresh;
        et            = item_reg.now - rd_reg.stamp;
        sum_wide      = {1'b0, rd_reg.sum} + (ips_pkg::SUM_W + 1)'(et);
        wrec          = base;
        res           = '0;
        we            = 1'b0;
        set_present   = 1'b0;
        clear_all     = 1'b0;
        unique case (item_reg.cmd) inside
            ips_pkg::CMD_CLEAR:
            begin
                clear_all = 1'b1;
            end
            ips_pkg::CMD_READ:
            begin
                if (sel_ok)
                    res = stats(rd_reg, ips_pkg::ST_OK);
                else
                    res.status = ips_pkg::ST_ABSENT;
            end
            ips_pkg::CMD_START, ips_pkg::CMD_STOP:
            begin
                if (!enable_reg || item_reg.skip)
                    res.status = ips_pkg::ST_IGNORED;
                else if (!slot_ok)
                    res.status = ips_pkg::ST_ABSENT;
                else if (item_reg.cmd == ips_pkg::CMD_START)
                begin
                    wrec.stamp   = item_reg.now;
                    if (base.running && (base.restarts != '1))
                        wrec.restarts = base.restarts + 1'b1;
                    wrec.running = 1'b1;
                    we           = 1'b1;
                    set_present  = 1'b1;
                    res          = stats(wrec, ips_pkg::ST_OK);
                end
                else if (!sel_ok)
                    res.status = ips_pkg::ST_ABSENT;
                else if (!rd_reg.running)
                    res = stats(rd_reg, ips_pkg::ST_NO_START);
                else
                begin
                    wrec.running = 1'b0;
                    if (rd_reg.calls != '1)
                        wrec.calls = rd_reg.calls + 1'b1;
                    if (et > rd_reg.tmax)
                        wrec.tmax = et;
                    if (et < rd_reg.tmin)
                        wrec.tmin = et;
                    // saturate the running total
                    if (sum_wide[ips_pkg::SUM_W])
                        wrec.sum = '1;
                    else
                        wrec.sum = sum_wide[ips_pkg::SUM_W-1:0];
                    we          = 1'b1;
                    res         = stats(wrec, ips_pkg::ST_OK);
                    res.elapsed = et;
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    // slot memory: one read at load, at most one write at execute
    always_ff @(posedge clk)
    begin
        if (ctl.load)
            rd_reg <= mem[in_idx];
        if (ctl.exec && we)
            mem[q_idx] <= wrec;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
            item_reg <= item;
        if (ctl.exec)
            result_reg <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            enable_reg  <= 1'b1;
        end
        else
        begin
            if (cfg_we)
                enable_reg <= cfg_data;
            if (ctl.exec && clear_all)
                present_reg <= '0;
            else if (ctl.exec && set_present)
                present_reg[q_idx] <= 1'b1;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// File: bench/tb_interval_profiler_slots.sv
// self-checking testbench for the interval profiler slot table
`default_nettype none

module tb_interval_profiler_slots;

    localparam int NSLOTS         = 16;
    localparam int WATCHDOG_LIMIT = 3000;   // cycles with no transaction at all
    localparam int SAT_PAIRS      = 4;      // a short burst of full-range stops on one slot

    // one queued command plus a flag that makes the sender wait for a drained pipe
    typedef struct {
        ips_pkg::item_t it;
        bit             drain;
    } queued_cmd_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    logic             busy;
    ips_pkg::item_t   cmd_item  = '0;
    logic             done;
    ips_pkg::result_t result;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic             cfg_data  = 1'b0;

    interval_profiler_slots #(.SLOTS(NSLOTS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (cmd_item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 12 unit period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // commands waiting to be sent and results waiting to come back
    queued_cmd_t      cmd_queue[$];
    ips_pkg::result_t pending_results[$];

    // shadow of the slot table and of the enable register
    logic                         slot_present [NSLOTS];
    logic                         slot_running [NSLOTS];
    logic [ips_pkg::STAMP_W-1:0]  slot_stamp   [NSLOTS];
    logic [ips_pkg::COUNT_W-1:0]  slot_calls   [NSLOTS];
    logic [ips_pkg::SUM_W-1:0]    slot_sum     [NSLOTS];
    logic [ips_pkg::STAMP_W-1:0]  slot_max     [NSLOTS];
    logic [ips_pkg::STAMP_W-1:0]  slot_min     [NSLOTS];
    logic [ips_pkg::COUNT_W-1:0]  slot_restarts[NSLOTS];
    logic                         enable_shadow = 1'b1;

    int          send_idle_pct = 0;
    int          idle_modes[3] = '{0, 87, 7};
    int unsigned mismatches    = 0;
    int unsigned queued_total  = 0;
    int unsigned sent_total    = 0;
    int unsigned timed_stops   = 0;
    int unsigned ignored_cmds  = 0;
    int unsigned restarts_seen = 0;
    int unsigned cfg_writes    = 0;
    bit          sum_saturated = 1'b0;

    initial
    begin
        for (int i = 0; i < NSLOTS; i++)
        begin
            slot_present[i] = 1'b0;
        end
    end

    // copy a slot's statistics into a result
    function automatic ips_pkg::result_t with_stats(ips_pkg::result_t r, int s);
        r.call_count    = slot_calls[s];
        r.total_time    = slot_sum[s];
        r.max_time      = slot_max[s];
        r.min_time      = slot_min[s];
        r.restart_count = slot_restarts[s];
        return r;
    endfunction

    // predicts the result of one command and updates the shadow table
    function automatic ips_pkg::result_t predict_profile(ips_pkg::item_t it);
        ips_pkg::result_t             r;
        logic [ips_pkg::STAMP_W-1:0]  et;
        logic [ips_pkg::SUM_W:0]      acc;
        int                           s;
        r = '0;
        s = int'(it.slot);
        if (it.cmd == ips_pkg::CMD_CLEAR)
        begin
            for (int i = 0; i < NSLOTS; i++)
            begin
                slot_present[i] = 1'b0;
            end
            return r;
        end
        if (it.cmd == ips_pkg::CMD_READ)
        begin
            if (!slot_present[s])
            begin
                r.status = ips_pkg::ST_ABSENT;
                return r;
            end
            return with_stats(r, s);
        end
        // start and stop are dropped before the slot is even looked at
        if (!enable_shadow || it.skip)
        begin
            ignored_cmds++;
            r.status = ips_pkg::ST_IGNORED;
            return r;
        end
        if (it.cmd == ips_pkg::CMD_START)
        begin
            if (!slot_present[s])
            begin
                slot_present[s]  = 1'b1;
                slot_running[s]  = 1'b0;
                slot_calls[s]    = '0;
                slot_sum[s]      = '0;
                slot_max[s]      = '0;
                slot_min[s]      = '1;
                slot_restarts[s] = '0;
            end
            slot_stamp[s] = it.now;
            if (slot_running[s])
            begin
                restarts_seen++;
                if (slot_restarts[s] != '1)
                begin
                    slot_restarts[s] = slot_restarts[s] + 1'b1;
                end
            end
            slot_running[s] = 1'b1;
            return with_stats(r, s);
        end
        // stop
        if (!slot_present[s])
        begin
            r.status = ips_pkg::ST_ABSENT;
            return r;
        end
        if (!slot_running[s])
        begin
            r.status = ips_pkg::ST_NO_START;
            return with_stats(r, s);
        end
        et = it.now - slot_stamp[s];
        timed_stops++;
        if (slot_calls[s] != '1)
        begin
            slot_calls[s] = slot_calls[s] + 1'b1;
        end
        slot_running[s] = 1'b0;
        if (et > slot_max[s])
        begin
            slot_max[s] = et;
        end
        if (et < slot_min[s])
        begin
            slot_min[s] = et;
        end
        acc = {1'b0, slot_sum[s]} + (ips_pkg::SUM_W + 1)'(et);
        if (acc[ips_pkg::SUM_W])
        begin
            slot_sum[s]   = '1;
            sum_saturated = 1'b1;
        end
        else
        begin
            slot_sum[s] = acc[ips_pkg::SUM_W-1:0];
        end
        r.elapsed = et;
        return with_stats(r, s);
    endfunction

    // driver: a command transaction is taken when start is high and busy low;
    // the next command goes out right away unless the sender idles or a drain mark holds it
    always @(posedge clk)
    begin : cmd_driver
        logic go;
        if (rst_n && start && !busy)
        begin
            pending_results.push_back(predict_profile(cmd_item));
            void'(cmd_queue.pop_front());
            sent_total++;
        end
        go = rst_n && cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct;
        // hold a marked command until every result ahead of it is back
        if (go && cmd_queue[0].drain && pending_results.size() != 0)
        begin
            go = 1'b0;
        end
        if (go)
        begin
            start    <= 1'b1;
            cmd_item <= cmd_queue[0].it;
        end
        else
        begin
            start <= 1'b0;
        end
    end

    task automatic compare_field(input string name, input logic [63:0] exp_v,
                                 input logic [63:0] act_v);
        if (act_v !== exp_v)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
        end
    endtask

    // monitor: done marks a result for exactly one cycle, taken at the edge ending it
    always @(posedge clk)
    begin : result_check
        ips_pkg::result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got %h", $time, result);
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("status", 64'(want.status), 64'(result.status));
                compare_field("elapsed", 64'(want.elapsed), 64'(result.elapsed));
                compare_field("call_count", 64'(want.call_count), 64'(result.call_count));
                compare_field("total_time", want.total_time, result.total_time);
                compare_field("max_time", 64'(want.max_time), 64'(result.max_time));
                compare_field("min_time", 64'(want.min_time), 64'(result.min_time));
                compare_field("restart_count", 64'(want.restart_count),
                              64'(result.restart_count));
            end
        end
    end

    // watchdog: ends the run after too long without any transaction
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done === 1'b1 || (cfg_valid && cfg_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic queue_cmd(input logic [1:0] c, input logic [3:0] s, input logic sk,
                             input logic [ips_pkg::STAMP_W-1:0] t, input bit drain = 1'b0);
        queued_cmd_t q;
        q.it.cmd  = c;
        q.it.slot = s;
        q.it.skip = sk;
        q.it.now  = t;
        q.drain   = drain;
        cmd_queue.push_back(q);
        queued_total++;
    endtask

    // timestamps over the whole range, with the ends now and then
    function automatic logic [ips_pkg::STAMP_W-1:0] rand_stamp();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return 48'({$urandom, $urandom});
        endcase
    endfunction

    // durations: short, mid-sized, full range (wraps the stamp), near the top
    function automatic logic [ips_pkg::STAMP_W-1:0] rand_delta();
        case ($urandom_range(3))
            0: return 48'($urandom_range(15));
            1: return 48'($urandom);
            2: return rand_stamp();
            default: return 48'hffff_ffff_ffff - 48'($urandom_range(3));
        endcase
    endfunction

    // mostly well-formed start/stop pairs with random content, plus noise
    task automatic queue_random(input int n);
        int unsigned                  first;
        int                           pick;
        bit                           d;
        logic [3:0]                   s;
        logic [ips_pkg::STAMP_W-1:0]  t;
        first = queued_total;
        while (queued_total - first < n)
        begin
            pick = int'($urandom_range(99));
            d    = ($urandom_range(49) == 0);
            s    = 4'($urandom_range(NSLOTS - 1));
            t    = rand_stamp();
            if (pick < 55)
            begin
                queue_cmd(ips_pkg::CMD_START, s, 1'b0, t, d);
                if ($urandom_range(4) == 0)
                begin
                    t = t + rand_delta();
                    queue_cmd(ips_pkg::CMD_START, s, 1'b0, t);
                end
                if ($urandom_range(9) == 0)
                begin
                    queue_cmd(ips_pkg::CMD_READ, s, 1'($urandom_range(1)), rand_stamp());
                end
                queue_cmd(ips_pkg::CMD_STOP, s, 1'b0, t + rand_delta());
                if ($urandom_range(3) == 0)
                begin
                    queue_cmd(ips_pkg::CMD_READ, s, 1'($urandom_range(1)), rand_stamp());
                end
            end
            else if (pick < 65)
            begin
                queue_cmd(ips_pkg::CMD_READ, s, 1'($urandom_range(1)), t, d);
            end
            else if (pick < 75)
            begin
                queue_cmd(ips_pkg::CMD_STOP, s, 1'b0, t, d);
            end
            else if (pick < 83)
            begin
                queue_cmd(ips_pkg::CMD_START, s, 1'b0, t, d);
            end
            else if (pick < 91)
            begin
                queue_cmd($urandom_range(1) ? ips_pkg::CMD_STOP : ips_pkg::CMD_START,
                          s, 1'b1, t, d);
            end
            else if (pick < 93)
            begin
                queue_cmd(ips_pkg::CMD_CLEAR, s, 1'($urandom_range(1)), t, d);
            end
            else
            begin
                queue_cmd(2'($urandom_range(3)), s, 1'($urandom_range(1)), t, d);
            end
        end
    endtask

    // let the queues empty, then let the pipe settle
    task automatic wait_idle();
        while (cmd_queue.size() != 0 || pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // one enable write transaction, only ever issued while idle
    task automatic write_enable(input logic v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
        begin
            @(posedge clk);
        end
        while (cfg_ready !== 1'b1);
        enable_shadow = v;
        cfg_writes++;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: absent slots, restart, wrapped and zero elapsed, skip, clear
        send_idle_pct = 0;
        queue_cmd(ips_pkg::CMD_CLEAR, 4'd0,  1'b1, '0);
        queue_cmd(ips_pkg::CMD_READ,  4'd0,  1'b0, '0);
        queue_cmd(ips_pkg::CMD_STOP,  4'd3,  1'b0, 48'd7);
        queue_cmd(ips_pkg::CMD_START, 4'd0,  1'b0, '0);
        queue_cmd(ips_pkg::CMD_START, 4'd0,  1'b0, 48'd5);
        queue_cmd(ips_pkg::CMD_READ,  4'd0,  1'b0, '1);
        queue_cmd(ips_pkg::CMD_STOP,  4'd0,  1'b0, 48'd2);
        queue_cmd(ips_pkg::CMD_STOP,  4'd0,  1'b0, 48'd9);
        queue_cmd(ips_pkg::CMD_START, 4'd15, 1'b1, '1);
        queue_cmd(ips_pkg::CMD_STOP,  4'd15, 1'b1, '1);
        queue_cmd(ips_pkg::CMD_START, 4'd15, 1'b0, '1);
        queue_cmd(ips_pkg::CMD_STOP,  4'd15, 1'b0, 48'h7fff_ffff_ffff);
        queue_cmd(ips_pkg::CMD_START, 4'd15, 1'b0, 48'h123);
        queue_cmd(ips_pkg::CMD_STOP,  4'd15, 1'b0, 48'h123);
        queue_cmd(ips_pkg::CMD_READ,  4'd15, 1'b1, '0);
        queue_cmd(ips_pkg::CMD_CLEAR, 4'd15, 1'b0, '1, 1'b1);
        queue_cmd(ips_pkg::CMD_READ,  4'd15, 1'b0, '0);
        queue_cmd(ips_pkg::CMD_STOP,  4'd0,  1'b0, 48'd3);
        queue_cmd(ips_pkg::CMD_START, 4'd0,  1'b0, 48'd100);
        queue_cmd(ips_pkg::CMD_STOP,  4'd0,  1'b0, '1);
        queue_cmd(ips_pkg::CMD_READ,  4'd0,  1'b0, '0);
        wait_idle();

        // disabled: start and stop are dropped, read and clear still work, also under random traffic
        write_enable(1'b0);
        queue_cmd(ips_pkg::CMD_START, 4'd4, 1'b0, 48'd10);
        queue_cmd(ips_pkg::CMD_STOP,  4'd0, 1'b0, 48'd20);
        queue_cmd(ips_pkg::CMD_READ,  4'd0, 1'b0, '0);
        queue_cmd(ips_pkg::CMD_CLEAR, 4'd0, 1'b0, '0);
        queue_cmd(ips_pkg::CMD_READ,  4'd0, 1'b0, '0);
        queue_random(120);
        wait_idle();

        // random phases cycling through the sender idle modes, with enable off in some
        for (int ph = 0; ph < 9; ph++)
        begin
            write_enable((ph % 4 == 2) ? 1'b0 : 1'b1);
            send_idle_pct = idle_modes[ph % 3];
            queue_random(165);
            wait_idle();
        end

        // back-to-back full-range stops on one slot
        write_enable(1'b1);
        send_idle_pct = 0;
        for (int i = 0; i < SAT_PAIRS; i++)
        begin
            queue_cmd(ips_pkg::CMD_START, 4'd9, 1'b0, 48'd1);
            queue_cmd(ips_pkg::CMD_STOP,  4'd9, 1'b0, 48'd0);
        end
        queue_cmd(ips_pkg::CMD_READ, 4'd9, 1'b0, '0);
        wait_idle();
        repeat (8) @(posedge clk);

        $display("run covered %0d commands: %0d timed stops, %0d restarts, %0d ignored",
                 sent_total, timed_stops, restarts_seen, ignored_cmds);
        $display("enable written %0d times, total time saturated: %0d",
                 cfg_writes, sum_saturated);
        if (mismatches == 0 && pending_results.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
design/ips_pkg.sv
design/ips_ctrl.sv
design/ips_dpath.sv
design/interval_profiler_slots.sv
bench/tb_interval_profiler_slots.sv
